>>> design/color_grading_pixel_pipeline_assert.svh
// Assertion macros for the color grading pixel pipeline checker.
`ifndef COLOR_GRADING_PIXEL_PIPELINE_ASSERT_SVH
`define COLOR_GRADING_PIXEL_PIPELINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CGP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define CGP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/cgp_pkg.sv
// Shared types, constants and clamp functions of the color grading pipeline.
`timescale 1ns / 1ps
package cgp_pkg;

	localparam int PIX_W  = 8;
	localparam int GAIN_W = 12;
	localparam int OFS_W  = 9;
	localparam int IDX_W  = 3;
	localparam int DATA_W = GAIN_W;
	localparam int ACC_W  = 23;

	typedef enum logic [IDX_W-1:0] {
		REG_BRIGHTNESS = 3'd0,
		REG_CONTRAST   = 3'd1,
		REG_SATURATION = 3'd2,
		REG_WARM_RED   = 3'd3,
		REG_WARM_BLUE  = 3'd4,
		REG_EXPOSURE   = 3'd5
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;

	typedef struct packed {
		logic signed [OFS_W-1:0] brightness;
		logic [GAIN_W-1:0]       contrast;
		logic [GAIN_W-1:0]       saturation;
		logic [GAIN_W-1:0]       warm_red;
		logic [GAIN_W-1:0]       warm_blue;
		logic [GAIN_W-1:0]       exposure;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_t;

	function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [9:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > 10'sd255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic logic [PIX_W-1:0] q8_to_byte(input logic signed [ACC_W-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v[ACC_W-1:16] != '0) begin
			return 8'd255;
		end
		return v[15:8];
	endfunction

endpackage

>>> design/cgp_cfg.sv
// Configuration register file of the color grading pipeline.
`timescale 1ns / 1ps
module cgp_cfg
	import cgp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness <= '0;
			cfg_q.contrast   <= GAIN_UNITY;
			cfg_q.saturation <= GAIN_UNITY;
			cfg_q.warm_red   <= GAIN_UNITY;
			cfg_q.warm_blue  <= GAIN_UNITY;
			cfg_q.exposure   <= GAIN_UNITY;
		end else if (wr) begin
			unique case (wr_index)
				REG_BRIGHTNESS: cfg_q.brightness <= $signed(wr_data[OFS_W-1:0]);
				REG_CONTRAST:   cfg_q.contrast   <= wr_data;
				REG_SATURATION: cfg_q.saturation <= wr_data;
				REG_WARM_RED:   cfg_q.warm_red   <= wr_data;
				REG_WARM_BLUE:  cfg_q.warm_blue  <= wr_data;
				REG_EXPOSURE:   cfg_q.exposure   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/cgp_tone.sv
// Brightness offset and contrast stages, two pipeline registers.
`timescale 1ns / 1ps
module cgp_tone
	import cgp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [OFS_W-1:0] brightness,
	input  logic [GAIN_W-1:0]       contrast,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pix_t                    in_pix,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pix_t                    out_pix
);

	logic valid_s1, valid_s2;
	pix_t pix_s1, pix_s2;
	pix_t bright, contr;
	logic adv1, adv2;

	function automatic logic [PIX_W-1:0] offset_ch(input logic [PIX_W-1:0] c,
	                                               input logic signed [OFS_W-1:0] o);
		logic signed [9:0] s;
		s = $signed({2'b00, c}) + 10'(o);
		return clamp_byte(s);
	endfunction

	function automatic logic [PIX_W-1:0] contrast_ch(input logic [PIX_W-1:0] c,
	                                                 input logic [GAIN_W-1:0] k);
		logic signed [8:0]       d;
		logic signed [ACC_W-1:0] v;
		d = $signed({1'b0, c}) - 9'sd128;
		v = $signed({1'b0, k}) * d + 23'sd32768;
		return q8_to_byte(v);
	endfunction

	always_comb begin
		bright.red   = offset_ch(in_pix.red, brightness);
		bright.green = offset_ch(in_pix.green, brightness);
		bright.blue  = offset_ch(in_pix.blue, brightness);
		contr.red    = contrast_ch(pix_s1.red, contrast);
		contr.green  = contrast_ch(pix_s1.green, contrast);
		contr.blue   = contrast_ch(pix_s1.blue, contrast);
	end

	assign adv2     = !valid_s2 || out_ready;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) pix_s1 <= bright;
		if (adv2) pix_s2 <= contr;
	end

	assign out_valid = valid_s2;
	assign out_pix   = pix_s2;

endmodule

>>> design/cgp_sat.sv
// Gray extraction and saturation stages, two pipeline registers.
`timescale 1ns / 1ps
module cgp_sat
	import cgp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GAIN_W-1:0] saturation,
	input  logic              in_valid,
	output logic              in_ready,
	input  pix_t              in_pix,
	output logic              out_valid,
	input  logic              out_ready,
	output pix_t              out_pix
);

	logic             valid_s3, valid_s4;
	pix_t             pix_s3, pix_s4;
	logic [PIX_W-1:0] gray_s3;
	logic [12:0]      wsum;
	pix_t             sat;
	logic             adv3, adv4;

	function automatic logic [PIX_W-1:0] sat_ch(input logic [PIX_W-1:0] c,
	                                            input logic [PIX_W-1:0] y,
	                                            input logic [GAIN_W-1:0] k);
		logic signed [8:0]       d;
		logic signed [ACC_W-1:0] v;
		d = $signed({1'b0, c}) - $signed({1'b0, y});
		v = $signed({7'b0, y, 8'b0}) + $signed({1'b0, k}) * d;
		return q8_to_byte(v);
	endfunction

	always_comb begin
		wsum = 13'(in_pix.red) * 13'd11 + 13'(in_pix.green) * 13'd16
		     + 13'(in_pix.blue) * 13'd5;
		sat.red   = sat_ch(pix_s3.red, gray_s3, saturation);
		sat.green = sat_ch(pix_s3.green, gray_s3, saturation);
		sat.blue  = sat_ch(pix_s3.blue, gray_s3, saturation);
	end

	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign in_ready = adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv3) valid_s3 <= in_valid;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			pix_s3  <= in_pix;
			gray_s3 <= wsum[12:5];
		end
		if (adv4) pix_s4 <= sat;
	end

	assign out_valid = valid_s4;
	assign out_pix   = pix_s4;

endmodule

>>> design/cgp_gain.sv
// Warmth and exposure gain stages, two pipeline registers.
`timescale 1ns / 1ps
module cgp_gain
	import cgp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GAIN_W-1:0] warm_red,
	input  logic [GAIN_W-1:0] warm_blue,
	input  logic [GAIN_W-1:0] exposure,
	input  logic              in_valid,
	output logic              in_ready,
	input  pix_t              in_pix,
	output logic              out_valid,
	input  logic              out_ready,
	output pix_t              out_pix
);

	logic valid_s5, valid_s6;
	pix_t pix_s5, pix_s6;
	pix_t warm, expo;
	logic adv5, adv6;

	function automatic logic [PIX_W-1:0] scale_ch(input logic [PIX_W-1:0] c,
	                                              input logic [GAIN_W-1:0] k);
		logic [PIX_W+GAIN_W-1:0] p;
		p = 20'(c) * 20'(k);
		return q8_to_byte($signed({3'b000, p}));
	endfunction

	always_comb begin
		warm.red   = scale_ch(in_pix.red, warm_red);
		warm.green = in_pix.green;
		warm.blue  = scale_ch(in_pix.blue, warm_blue);
		expo.red   = scale_ch(pix_s5.red, exposure);
		expo.green = scale_ch(pix_s5.green, exposure);
		expo.blue  = scale_ch(pix_s5.blue, exposure);
	end

	assign adv6     = !valid_s6 || out_ready;
	assign adv5     = !valid_s5 || adv6;
	assign in_ready = adv5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv5) valid_s5 <= in_valid;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) pix_s5 <= warm;
		if (adv6) pix_s6 <= expo;
	end

	assign out_valid = valid_s6;
	assign out_pix   = pix_s6;

endmodule

>>> design/color_grading_pixel_pipeline.sv
// Color grading pixel pipeline top level.
// Grades one 8-bit RGB pixel per clock while in_stall is low: brightness
// offset, contrast about 128, saturation away from gray (r*11+g*16+b*5)/32,
// warmth gains on red and blue, then exposure gain, each step truncated and
// clamped to 0..255. Gains are unsigned Q4.8 (256 is unity), the offset is
// a 9-bit signed value. The pipeline has six register stages, at most one
// multiplier deep each, and takes a new pixel every cycle unless stalled.
// Every stage holds its word independently: a stall at the output fills
// empty stages before it reaches in_stall. Write registers only while idle.
`timescale 1ns / 1ps
module color_grading_pixel_pipeline
	import cgp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  in_red,
	input  logic [PIX_W-1:0]  in_green,
	input  logic [PIX_W-1:0]  in_blue,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  out_red,
	output logic [PIX_W-1:0]  out_green,
	output logic [PIX_W-1:0]  out_blue
);

	cfg_t cfg;
	pix_t in_pix, tone_pix, sat_pix, grade_pix;
	logic tone_in_ready, tone_valid, sat_in_ready, sat_valid, gain_in_ready;

	assign cfg_ready = 1'b1;

	cgp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign in_pix.red   = in_red;
	assign in_pix.green = in_green;
	assign in_pix.blue  = in_blue;
	assign in_stall     = !tone_in_ready;

	cgp_tone u_tone (
		.clk        (clk),
		.arst_n     (arst_n),
		.brightness (cfg.brightness),
		.contrast   (cfg.contrast),
		.in_valid   (in_valid),
		.in_ready   (tone_in_ready),
		.in_pix     (in_pix),
		.out_valid  (tone_valid),
		.out_ready  (sat_in_ready),
		.out_pix    (tone_pix)
	);

	cgp_sat u_sat (
		.clk        (clk),
		.arst_n     (arst_n),
		.saturation (cfg.saturation),
		.in_valid   (tone_valid),
		.in_ready   (sat_in_ready),
		.in_pix     (tone_pix),
		.out_valid  (sat_valid),
		.out_ready  (gain_in_ready),
		.out_pix    (sat_pix)
	);

	cgp_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.warm_red  (cfg.warm_red),
		.warm_blue (cfg.warm_blue),
		.exposure  (cfg.exposure),
		.in_valid  (sat_valid),
		.in_ready  (gain_in_ready),
		.in_pix    (sat_pix),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_pix   (grade_pix)
	);

	assign out_red   = grade_pix.red;
	assign out_green = grade_pix.green;
	assign out_blue  = grade_pix.blue;

endmodule

>>> design/cgp_checker.sv
// Port-level checker for the color grading pipeline, bound to the top level.
`timescale 1ns / 1ps
`include "color_grading_pixel_pipeline_assert.svh"
module cgp_checker
	import cgp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [PIX_W-1:0]  out_red,
	input logic [PIX_W-1:0]  out_green,
	input logic [PIX_W-1:0]  out_blue
);

	`CGP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`CGP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable({out_red, out_green, out_blue}))
	`CGP_ASSERT_NOW(a_no_stall_when_draining, !out_valid || !out_stall, !in_stall)
	`CGP_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind color_grading_pixel_pipeline cgp_checker u_cgp_checker (.*);
